/* hw/rtl/kli_pkg.sv */
// ----------------------------------------------------------------------------
// kli_pkg: shared types and codes for the keyframe interpolator
// Key entry layout, request and status codes, sequencer states and the
// control bundle of the shared multiply/divide unit.
// ----------------------------------------------------------------------------
package kli_pkg;

	localparam int VAL_W     = 32;
	localparam int DIV_STEPS = 32;
	localparam int STEP_W    = $clog2(DIV_STEPS);

	// one stored keyframe
	typedef struct packed {
		logic signed [VAL_W-1:0] t;
		logic signed [VAL_W-1:0] x;
		logic signed [VAL_W-1:0] y;
	} key_t;

	typedef enum logic [1:0] {
		MODE_ADD   = 2'd0,
		MODE_CUT   = 2'd1,
		MODE_QUERY = 2'd2
	} mode_t;

	typedef enum logic [1:0] {
		STAT_OK    = 2'd0,
		STAT_FULL  = 2'd1,
		STAT_EMPTY = 2'd2
	} status_t;

	// main sequencer
	typedef enum logic [3:0] {
		ST_IDLE,
		ST_DISPATCH,
		ST_ADD_RD,
		ST_ADD_CHK,
		ST_ADD_PUT,
		ST_CUT_RD,
		ST_CUT_CHK,
		ST_Q_FIRST,
		ST_Q_LAST,
		ST_Q_RDR,
		ST_Q_CHKR,
		ST_ARG,
		ST_MD_GO,
		ST_MD_WAIT,
		ST_DONE
	} state_t;

	// multiply/divide unit phases
	typedef enum logic [1:0] {
		MD_IDLE,
		MD_MUL,
		MD_DIV
	} md_state_t;

	// request to the multiply/divide unit: quo = floor(mag * num / den)
	typedef struct packed {
		logic             start;
		logic [VAL_W-1:0] mag;
		logic [VAL_W-1:0] num;
		logic [VAL_W-1:0] den;
	} md_req_t;

	typedef struct packed {
		logic             busy;
		logic             done;
		logic [VAL_W-1:0] quo;
	} md_rsp_t;

endpackage

/* hw/rtl/kli_key_mem.sv */
// ----------------------------------------------------------------------------
// kli_key_mem: keyframe table storage
// Single-port memory of key entries, one access per cycle, registered read.
// ----------------------------------------------------------------------------
module kli_key_mem
	import kli_pkg::*;
#(
	parameter int DEPTH = 16,
	parameter int AW    = 4
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] addr,
	input  key_t          wdata,
	output key_t          rdata
);

	key_t mem_q [DEPTH];
	key_t rdata_q;

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[addr] <= wdata;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		rdata_q <= mem_q[addr];
	end

	assign rdata = rdata_q;

endmodule

/* hw/rtl/kli_muldiv.sv */
// ----------------------------------------------------------------------------
// kli_muldiv: shared scale unit
// One 32x32 multiply, then a restoring divide one quotient bit per cycle.
// The caller guarantees num < den, so the quotient fits in 32 bits.
// ----------------------------------------------------------------------------
module kli_muldiv
	import kli_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  md_req_t req,
	output md_rsp_t rsp
);

	md_state_t         state_q;
	md_state_t         state_d;
	logic [STEP_W-1:0] step_q;
	logic              done_q;
	logic [VAL_W-1:0]  a_q;
	logic [VAL_W-1:0]  b_q;
	logic [VAL_W-1:0]  den_q;
	logic [VAL_W-1:0]  rem_q;
	logic [VAL_W-1:0]  lo_q;

	logic [2*VAL_W-1:0] prod;
	logic [VAL_W:0]     trial;
	logic [VAL_W:0]     diff;
	logic               qbit;

	// multiplier and one divide step
	always_comb begin
		prod  = a_q * b_q;
		trial = {rem_q, lo_q[VAL_W-1]};
		diff  = trial - {1'b0, den_q};
		qbit  = !diff[VAL_W];
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			MD_IDLE: begin
				if (req.start) begin
					state_d = MD_MUL;
				end
			end
			MD_MUL: state_d = MD_DIV;
			MD_DIV: begin
				if (step_q == STEP_W'(DIV_STEPS - 1)) begin
					state_d = MD_IDLE;
				end
			end
			default: state_d = MD_IDLE;
		endcase
	end

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= MD_IDLE;
			step_q  <= '0;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			done_q  <= (state_q == MD_DIV) && (state_d == MD_IDLE);
			if (state_q == MD_MUL) begin
				step_q <= '0;
			end else if (state_q == MD_DIV) begin
				step_q <= step_q + STEP_W'(1);
			end
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		if (state_q == MD_IDLE && req.start) begin
			a_q   <= req.mag;
			b_q   <= req.num;
			den_q <= req.den;
		end
		if (state_q == MD_MUL) begin
			rem_q <= prod[2*VAL_W-1:VAL_W];
			lo_q  <= prod[VAL_W-1:0];
		end else if (state_q == MD_DIV) begin
			rem_q <= qbit ? diff[VAL_W-1:0] : trial[VAL_W-1:0];
			lo_q  <= {lo_q[VAL_W-2:0], qbit};
		end
	end

	// status outputs
	always_comb begin
		rsp.busy = (state_q != MD_IDLE);
		rsp.done = done_q;
		rsp.quo  = lo_q;
	end

endmodule

/* hw/rtl/keyframe_linear_interpolator.sv */
// ----------------------------------------------------------------------------
// keyframe_linear_interpolator: sorted 2-D keyframe table with lerp queries
// Add, truncate and query requests over a time-sorted table of keys.
// ----------------------------------------------------------------------------
// Usage
//   Request channel (req_valid/req_stall): mode, time_req, value_x, value_y.
//   Result channel (rsp_valid/rsp_stall): out_x, out_y, later_exists,
//   stored_keys, status. Exactly one result word per request word.
//   One request is worked on at a time; req_stall is high until the
//   sequencer is back in idle. The table sits in a single-port memory,
//   so each scanned or shifted entry takes a read state and a check state.
//   Add moves up every key whose time is not below the new one (a full
//   table drops the add); truncate inspects keys from the top down.
//   Query: empty or clamped queries skip the multiply/divide path; others
//   scan for the bracketing keys, then run that path once per lane (x then
//   y): setup, start, one multiply, 32 divide steps, done.
//   The result register lets the next request be taken while a result
//   waits; a finished request holds in its last state until the result
//   register frees up. Reset empties the table and drops any result.
// ----------------------------------------------------------------------------
module keyframe_linear_interpolator
	import kli_pkg::*;
#(
	parameter int MAX_KEYS = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               req_valid,
	output logic               req_stall,
	input  logic [1:0]         mode,
	input  logic signed [31:0] time_req,
	input  logic signed [31:0] value_x,
	input  logic signed [31:0] value_y,
	output logic               rsp_valid,
	input  logic               rsp_stall,
	output logic signed [31:0] out_x,
	output logic signed [31:0] out_y,
	output logic               later_exists,
	output logic [4:0]         stored_keys,
	output logic [1:0]         status
);

	localparam int AW = (MAX_KEYS > 1) ? $clog2(MAX_KEYS) : 1;
	localparam int CW = $clog2(MAX_KEYS + 1);

	state_t state_q;
	state_t state_d;

	// request word and working registers
	logic [1:0]              mode_q;
	logic signed [VAL_W-1:0] t_q;
	logic signed [VAL_W-1:0] vx_q;
	logic signed [VAL_W-1:0] vy_q;
	logic [CW-1:0]           count_q;
	logic [CW-1:0]           idx_q;
	logic signed [VAL_W-1:0] last_t_q;
	key_t                    left_q;
	key_t                    right_q;
	logic                    sel_y_q;
	logic                    neg_q;
	logic [VAL_W-1:0]        mag_q;
	logic [VAL_W-1:0]        num_q;
	logic [VAL_W-1:0]        den_q;
	logic signed [VAL_W-1:0] res_x_q;
	logic signed [VAL_W-1:0] res_y_q;
	status_t                 res_st_q;

	// result register
	logic                    rsp_valid_q;
	logic signed [VAL_W-1:0] out_x_q;
	logic signed [VAL_W-1:0] out_y_q;
	logic                    later_q;
	logic [4:0]              keys_q;
	status_t                 status_q;

	// memory and unit hookup
	logic          mem_we;
	logic [CW-1:0] mem_idx;
	key_t          mem_wdata;
	key_t          mem_rdata;
	md_req_t       md_req;
	md_rsp_t       md_rsp;

	// lane operands
	logic signed [VAL_W-1:0] lane_l;
	logic signed [VAL_W-1:0] lane_r;
	logic [VAL_W:0]          dv;
	logic [VAL_W:0]          dv_neg;
	logic [VAL_W-1:0]        lane_res;
	logic                    out_free;
	logic [31:0]             count_ext;

	kli_key_mem #(
		.DEPTH (MAX_KEYS),
		.AW    (AW)
	) u_mem (
		.clk   (clk),
		.we    (mem_we),
		.addr  (mem_idx[AW-1:0]),
		.wdata (mem_wdata),
		.rdata (mem_rdata)
	);

	kli_muldiv u_md (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (md_req),
		.rsp    (md_rsp)
	);

	// lane select and interpolation arithmetic
	always_comb begin
		lane_l   = sel_y_q ? left_q.y : left_q.x;
		lane_r   = sel_y_q ? right_q.y : right_q.x;
		dv       = {lane_r[VAL_W-1], lane_r} - {lane_l[VAL_W-1], lane_l};
		dv_neg   = -dv;
		lane_res = neg_q ? (lane_l - md_rsp.quo) : (lane_l + md_rsp.quo);
	end

	assign out_free  = !rsp_valid_q || !rsp_stall;
	assign count_ext = 32'(count_q);

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (req_valid) begin
					state_d = ST_DISPATCH;
				end
			end
			ST_DISPATCH: begin
				case (mode_q)
					MODE_ADD: begin
						if (count_q == CW'(MAX_KEYS)) begin
							state_d = ST_DONE;
						end else if (count_q == '0) begin
							state_d = ST_ADD_PUT;
						end else begin
							state_d = ST_ADD_RD;
						end
					end
					MODE_CUT: state_d = (count_q == '0) ? ST_DONE : ST_CUT_RD;
					MODE_QUERY: state_d = (count_q == '0) ? ST_DONE : ST_Q_FIRST;
					default: state_d = ST_DONE;
				endcase
			end
			ST_ADD_RD: state_d = ST_ADD_CHK;
			ST_ADD_CHK: begin
				if (mem_rdata.t >= t_q && idx_q != CW'(1)) begin
					state_d = ST_ADD_RD;
				end else begin
					state_d = ST_ADD_PUT;
				end
			end
			ST_ADD_PUT: state_d = ST_DONE;
			ST_CUT_RD: state_d = ST_CUT_CHK;
			ST_CUT_CHK: begin
				if (mem_rdata.t <= t_q || idx_q == CW'(1)) begin
					state_d = ST_DONE;
				end else begin
					state_d = ST_CUT_RD;
				end
			end
			ST_Q_FIRST: begin
				if (t_q <= mem_rdata.t) begin
					state_d = ST_DONE;
				end else if (t_q >= last_t_q) begin
					state_d = ST_Q_LAST;
				end else begin
					state_d = ST_Q_RDR;
				end
			end
			ST_Q_LAST: state_d = ST_DONE;
			ST_Q_RDR: state_d = ST_Q_CHKR;
			ST_Q_CHKR: state_d = (mem_rdata.t > t_q) ? ST_ARG : ST_Q_RDR;
			ST_ARG: state_d = ST_MD_GO;
			ST_MD_GO: state_d = ST_MD_WAIT;
			ST_MD_WAIT: begin
				if (md_rsp.done) begin
					state_d = sel_y_q ? ST_DONE : ST_ARG;
				end
			end
			ST_DONE: begin
				if (out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// sequencer outputs: memory access, unit start, request stall
	always_comb begin
		mem_we     = 1'b0;
		mem_idx    = '0;
		mem_wdata  = mem_rdata;
		md_req     = '{start: 1'b0, mag: mag_q, num: num_q, den: den_q};
		req_stall  = (state_q != ST_IDLE);
		unique case (state_q)
			ST_DISPATCH: mem_idx = '0;
			ST_ADD_RD,
			ST_CUT_RD: mem_idx = idx_q - CW'(1);
			ST_ADD_CHK: begin
				mem_idx = idx_q;
				mem_we  = (mem_rdata.t >= t_q);
			end
			ST_ADD_PUT: begin
				mem_idx   = idx_q;
				mem_we    = 1'b1;
				mem_wdata = '{t: t_q, x: vx_q, y: vy_q};
			end
			ST_Q_FIRST: mem_idx = count_q - CW'(1);
			ST_Q_RDR: mem_idx = idx_q;
			ST_MD_GO: md_req.start = 1'b1;
			default: mem_idx = '0;
		endcase
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			count_q     <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_ADD_PUT) begin
				count_q <= count_q + CW'(1);
			end
			if (state_q == ST_CUT_CHK) begin
				if (mem_rdata.t <= t_q) begin
					count_q <= idx_q;
				end else if (idx_q == CW'(1)) begin
					count_q <= '0;
				end
			end
			if (state_q == ST_DONE && out_free) begin
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	// working datapath
	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				mode_q   <= mode;
				t_q      <= time_req;
				vx_q     <= value_x;
				vy_q     <= value_y;
				idx_q    <= count_q;
				sel_y_q  <= 1'b0;
				res_x_q  <= '0;
				res_y_q  <= '0;
				res_st_q <= STAT_OK;
			end
			ST_DISPATCH: begin
				if (mode_q == MODE_ADD && count_q == CW'(MAX_KEYS)) begin
					res_st_q <= STAT_FULL;
				end
				if (mode_q == MODE_QUERY && count_q == '0) begin
					res_st_q <= STAT_EMPTY;
				end
			end
			ST_ADD_CHK: begin
				if (mem_rdata.t >= t_q) begin
					idx_q <= idx_q - CW'(1);
				end
			end
			ST_ADD_PUT: begin
				if (idx_q == count_q) begin
					last_t_q <= t_q;
				end
			end
			ST_CUT_CHK: begin
				if (mem_rdata.t <= t_q) begin
					last_t_q <= mem_rdata.t;
				end else begin
					idx_q <= idx_q - CW'(1);
				end
			end
			ST_Q_FIRST: begin
				left_q <= mem_rdata;
				idx_q  <= CW'(1);
				if (t_q <= mem_rdata.t) begin
					res_x_q <= mem_rdata.x;
					res_y_q <= mem_rdata.y;
				end
			end
			ST_Q_LAST: begin
				res_x_q <= mem_rdata.x;
				res_y_q <= mem_rdata.y;
			end
			ST_Q_CHKR: begin
				if (mem_rdata.t > t_q) begin
					right_q <= mem_rdata;
				end else begin
					left_q <= mem_rdata;
					idx_q  <= idx_q + CW'(1);
				end
			end
			ST_ARG: begin
				neg_q <= dv[VAL_W];
				mag_q <= dv[VAL_W] ? dv_neg[VAL_W-1:0] : dv[VAL_W-1:0];
				num_q <= t_q - left_q.t;
				den_q <= right_q.t - left_q.t;
			end
			ST_MD_WAIT: begin
				if (md_rsp.done) begin
					if (sel_y_q) begin
						res_y_q <= lane_res;
					end else begin
						res_x_q <= lane_res;
					end
					sel_y_q <= 1'b1;
				end
			end
			default: begin
			end
		endcase
	end

	// result register load
	always_ff @(posedge clk) begin
		if (state_q == ST_DONE && out_free) begin
			out_x_q  <= res_x_q;
			out_y_q  <= res_y_q;
			later_q  <= (count_q != '0) && (last_t_q > t_q);
			keys_q   <= count_ext[4:0];
			status_q <= res_st_q;
		end
	end

	assign rsp_valid    = rsp_valid_q;
	assign out_x        = out_x_q;
	assign out_y        = out_y_q;
	assign later_exists = later_q;
	assign stored_keys  = keys_q;
	assign status       = status_q;

`ifndef ASSERT_OFF
	// table never holds more keys than it has room for
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(MAX_KEYS))
		else $error("key count beyond table size");

	// a full status comes with a full key count
	a_full_status: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && status == STAT_FULL) |-> (stored_keys == 5'(MAX_KEYS)))
		else $error("full status with room left");

	// an empty query returns zero values and no keys
	a_empty_status: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && status == STAT_EMPTY) |->
			(stored_keys == 5'd0 && out_x == '0 && out_y == '0))
		else $error("empty status with data");

	// the scale unit is never restarted while busy
	a_md_start: assert property (@(posedge clk) disable iff (!arst_n)
		md_req.start |-> !md_rsp.busy)
		else $error("scale unit started while busy");
`endif

endmodule
